/* rtl/rmsm_pkg.sv */
// Shared types, constants and a helper function of the running mean and second moment block.
`default_nettype none
package rmsm_pkg;

	localparam int unsigned DIM_DEF  = 4;
	localparam int unsigned NREP_MAX = 4;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MEAN_W   = 32;
	localparam int unsigned MOM_W    = 48;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned DIFF_W   = 49;
	localparam int unsigned DVD_W    = 50;
	localparam int unsigned DVS_W    = 33;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] elem_0;
		logic signed [SAMPLE_W-1:0] elem_1;
		logic signed [SAMPLE_W-1:0] elem_2;
		logic signed [SAMPLE_W-1:0] elem_3;
		logic                       restart;
	} obs_t;

	typedef struct packed {
		logic [1:0]              row_index;
		logic signed [MEAN_W-1:0] mean_value;
		logic signed [MOM_W-1:0]  moment_col_0;
		logic signed [MOM_W-1:0]  moment_col_1;
		logic signed [MOM_W-1:0]  moment_col_2;
		logic signed [MOM_W-1:0]  moment_col_3;
		logic [CNT_W-1:0]         obs_count;
		logic                     last_row;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_DIV,
		ST_WB,
		ST_EMIT
	} state_t;

	// Components beyond the fourth repeat sample 0.
	function automatic logic signed [SAMPLE_W-1:0] lane_sample(input obs_t o, input int idx);
		logic signed [SAMPLE_W-1:0] s;
		case (idx)
			1:       s = o.elem_1;
			2:       s = o.elem_2;
			3:       s = o.elem_3;
			default: s = o.elem_0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* rtl/running_mean_second_moment.sv */
// Top level of the online mean and second-moment matrix estimator.
//
//   channel | direction | handshake             | beat payload
//   --------+-----------+-----------------------+------------------------------------
//   obs     | in        | obs_valid / obs_stall | rmsm_pkg::obs_t, samples and restart
//   res     | out       | res_valid / res_stall | rmsm_pkg::res_t, one matrix row
//
// Each observation updates DIM mean entries and DIM*DIM moment entries one at a time.
// Every entry passes through the bit-serial divider, which forms round(diff / (n+1))
// one quotient bit per cycle while it is busy.
// Reset clears the count, the mean and the moment valid bits at once; no clearing pass.
// A two-beat queue accepts observations while the engine works until both slots are
// full, and a held result does not stop the queue from filling.
`default_nettype none
module running_mean_second_moment #(
	parameter int unsigned DIM = rmsm_pkg::DIM_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           obs_valid,
	output logic                obs_stall,
	input  wire rmsm_pkg::obs_t obs,
	output logic                res_valid,
	input  wire logic           res_stall,
	output rmsm_pkg::res_t      res
);

	logic           q_valid;
	logic           q_pop;
	rmsm_pkg::obs_t q_item;

	// Front: observations are taken into the queue whenever it has room.
	rmsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (obs_valid),
		.push_item  (obs),
		.full       (obs_stall),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (q_item)
	);

	// Back: the update engine drains the queue one observation at a time.
	rmsm_back #(
		.DIM (DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire

/* rtl/rmsm_queue.sv */
// Two-entry queue that decouples the accepting front from the update engine.
`default_nettype none
module rmsm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire rmsm_pkg::obs_t push_item,
	output logic               full,
	input  wire logic          pop,
	output logic               pop_valid,
	output rmsm_pkg::obs_t     pop_item
);

	rmsm_pkg::obs_t slots_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     fill_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (fill_q == 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_item  = slots_q[rd_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rmsm_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module rmsm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rmsm_pkg::DVD_W-1:0]    dividend,
	input  wire logic [rmsm_pkg::DVS_W-1:0]    divisor,
	output logic                               done,
	output logic [rmsm_pkg::DVD_W-1:0]         quotient
);

	localparam int unsigned N  = rmsm_pkg::DVD_W;
	localparam int unsigned D  = rmsm_pkg::DVS_W;
	localparam int unsigned CW = $clog2(N + 1);

	logic [N-1:0]  dvd_q;
	logic [D-1:0]  dvs_q;
	logic [D-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D:0]    rem_sh;
	logic [D:0]    rem_sub;
	logic          ge;

	assign rem_sh  = {rem_q, dvd_q[N-1]};
	assign ge      = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[N-2:0], ge};
			rem_q <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

/* rtl/rmsm_back.sv */
// Update engine: walks every mean and moment entry of an observation and emits row results.
`default_nettype none
module rmsm_back #(
	parameter int unsigned DIM = rmsm_pkg::DIM_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire rmsm_pkg::obs_t q_item,
	output logic                q_pop,
	output logic                res_valid,
	input  wire logic           res_stall,
	output rmsm_pkg::res_t      res
);

	localparam int unsigned NENT = DIM * DIM;
	localparam int unsigned AW   = (NENT > 1) ? $clog2(NENT) : 1;
	localparam int unsigned RW   = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int unsigned NREP = (DIM < rmsm_pkg::NREP_MAX) ? DIM : rmsm_pkg::NREP_MAX;
	localparam logic [RW-1:0] LAST_IDX = RW'(DIM - 1);
	localparam logic [RW:0]   NREP_V   = (RW + 1)'(NREP);
	localparam int unsigned MW = rmsm_pkg::MOM_W;
	localparam int unsigned EW = rmsm_pkg::MEAN_W;
	localparam int unsigned SW = rmsm_pkg::SAMPLE_W;

	rmsm_pkg::state_t state_q, state_d;

	logic [RW-1:0]                 row_q;
	logic [RW-1:0]                 col_q;
	logic                          mean_sel_q;
	logic [AW-1:0]                 addr_q;
	logic [rmsm_pkg::CNT_W-1:0]    count_q;
	logic [rmsm_pkg::DVS_W-1:0]    div_q;
	logic [NENT-1:0]               valid_q;
	logic signed [SW-1:0]          xr_q [DIM];
	logic signed [SW-1:0]          xc_q [DIM];
	logic signed [EW-1:0]          mean_q [DIM];
	logic [MW-1:0]                 mem [NENT];
	logic [MW-1:0]                 rd_q;
	logic signed [2*SW-1:0]        prod_q;
	logic signed [MW-1:0]          old_q;
	logic                          neg_q;
	logic signed [EW-1:0]          rb_mean_q;
	logic signed [MW-1:0]          rb_col_q [rmsm_pkg::NREP_MAX];
	rmsm_pkg::res_t                out_q;
	logic                          out_valid_q;

	logic                          div_start;
	logic                          div_done;
	logic [rmsm_pkg::DVD_W-1:0]    dividend;
	logic [rmsm_pkg::DVD_W-1:0]    quot;
	logic signed [MW-1:0]          old_d;
	logic signed [MW-1:0]          target_d;
	logic signed [rmsm_pkg::DIFF_W-1:0] diff_d;
	logic [rmsm_pkg::DIFF_W-1:0]   mag_d;
	logic signed [MW+2:0]          wb_sum;
	logic                          out_load;
	logic                          row_end;
	logic                          row_report;
	logic                          obs_end;
	logic [rmsm_pkg::CNT_W-1:0]    base_cnt;

	rmsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (div_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Operand preparation for the entry in hand.
	always_comb begin
		if (mean_sel_q) begin
			old_d    = MW'(mean_q[row_q]);
			target_d = MW'($signed({xr_q[0], {rmsm_pkg::FRAC_W{1'b0}}}));
		end else begin
			old_d    = valid_q[addr_q] ? $signed(rd_q) : '0;
			target_d = $signed({prod_q, {rmsm_pkg::FRAC_W{1'b0}}});
		end
		diff_d   = rmsm_pkg::DIFF_W'(target_d) - rmsm_pkg::DIFF_W'(old_d);
		mag_d    = diff_d[rmsm_pkg::DIFF_W-1] ? rmsm_pkg::DIFF_W'(-diff_d) : diff_d;
		dividend = {1'b0, mag_d} + rmsm_pkg::DVD_W'(div_q[rmsm_pkg::DVS_W-1:1]);
	end

	assign wb_sum = neg_q ? ((MW+3)'(old_q) - $signed({1'b0, quot}))
	                      : ((MW+3)'(old_q) + $signed({1'b0, quot}));

	assign row_end    = !mean_sel_q && (col_q == LAST_IDX);
	assign row_report = ({1'b0, row_q} < NREP_V);
	assign obs_end    = (row_q == LAST_IDX);
	assign base_cnt   = q_item.restart ? '0 : count_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmsm_pkg::ST_IDLE: begin
				if (q_valid) state_d = rmsm_pkg::ST_READ;
			end
			rmsm_pkg::ST_READ: state_d = rmsm_pkg::ST_PREP;
			rmsm_pkg::ST_PREP: state_d = rmsm_pkg::ST_DIV;
			rmsm_pkg::ST_DIV: begin
				if (div_done) state_d = rmsm_pkg::ST_WB;
			end
			rmsm_pkg::ST_WB: begin
				if (!row_end) state_d = rmsm_pkg::ST_READ;
				else if (row_report) state_d = rmsm_pkg::ST_EMIT;
				else if (obs_end) state_d = rmsm_pkg::ST_IDLE;
				else state_d = rmsm_pkg::ST_READ;
			end
			rmsm_pkg::ST_EMIT: begin
				if (!out_valid_q || !res_stall) begin
					state_d = obs_end ? rmsm_pkg::ST_IDLE : rmsm_pkg::ST_READ;
				end
			end
			default: state_d = rmsm_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			rmsm_pkg::ST_IDLE: q_pop = q_valid;
			rmsm_pkg::ST_PREP: div_start = 1'b1;
			rmsm_pkg::ST_EMIT: out_load = !out_valid_q || !res_stall;
			default: ;
		endcase
	end

	// Moment store, no reset; entries not yet written read as zero through valid_q.
	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
		if (state_q == rmsm_pkg::ST_WB && !mean_sel_q) begin
			mem[addr_q] <= wb_sum[MW-1:0];
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == rmsm_pkg::ST_READ) begin
			prod_q <= xr_q[0] * xc_q[0];
		end
		if (state_q == rmsm_pkg::ST_PREP) begin
			old_q <= old_d;
			neg_q <= diff_d[rmsm_pkg::DIFF_W-1];
		end
		if (q_pop) begin
			for (int i = 0; i < DIM; i++) begin
				xr_q[i] <= rmsm_pkg::lane_sample(q_item, i);
				xc_q[i] <= rmsm_pkg::lane_sample(q_item, i);
			end
		end else begin
			if (state_q == rmsm_pkg::ST_WB && !mean_sel_q) begin
				for (int i = 0; i < DIM; i++) begin
					xc_q[i] <= xc_q[(i + 1) % DIM];
				end
			end
			if (out_load || (state_q == rmsm_pkg::ST_WB && row_end && !row_report)) begin
				for (int i = 0; i < DIM; i++) begin
					xr_q[i] <= xr_q[(i + 1) % DIM];
				end
			end
		end
		if (q_pop || out_load) begin
			rb_mean_q <= '0;
			for (int c = 0; c < rmsm_pkg::NREP_MAX; c++) rb_col_q[c] <= '0;
		end else if (state_q == rmsm_pkg::ST_WB) begin
			if (mean_sel_q) begin
				rb_mean_q <= wb_sum[EW-1:0];
			end else begin
				for (int c = 0; c < rmsm_pkg::NREP_MAX; c++) begin
					if (c < DIM && col_q == RW'(c)) rb_col_q[c] <= wb_sum[MW-1:0];
				end
			end
		end
		if (out_load) begin
			out_q.row_index    <= 2'(row_q);
			out_q.mean_value   <= rb_mean_q;
			out_q.moment_col_0 <= rb_col_q[0];
			out_q.moment_col_1 <= rb_col_q[1];
			out_q.moment_col_2 <= rb_col_q[2];
			out_q.moment_col_3 <= rb_col_q[3];
			out_q.obs_count    <= count_q;
			out_q.last_row     <= ({1'b0, row_q} == NREP_V - 1'b1);
		end
	end

	// Control state and running statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmsm_pkg::ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			mean_sel_q  <= 1'b1;
			addr_q      <= '0;
			count_q     <= '0;
			div_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIM; i++) mean_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				count_q    <= (base_cnt == rmsm_pkg::CNT_MAX) ? base_cnt : base_cnt + 1'b1;
				div_q      <= {1'b0, base_cnt} + 1'b1;
				row_q      <= '0;
				col_q      <= '0;
				mean_sel_q <= 1'b1;
				addr_q     <= '0;
				if (q_item.restart) begin
					valid_q <= '0;
					for (int i = 0; i < DIM; i++) mean_q[i] <= '0;
				end
			end else if (state_q == rmsm_pkg::ST_WB) begin
				if (mean_sel_q) begin
					mean_q[row_q] <= wb_sum[EW-1:0];
					mean_sel_q    <= 1'b0;
					col_q         <= '0;
				end else begin
					valid_q[addr_q] <= 1'b1;
					addr_q          <= addr_q + 1'b1;
					if (!row_end) begin
						col_q <= col_q + 1'b1;
					end else if (!row_report && !obs_end) begin
						row_q      <= row_q + 1'b1;
						mean_sel_q <= 1'b1;
					end
				end
			end else if (out_load && !obs_end) begin
				row_q      <= row_q + 1'b1;
				mean_sel_q <= 1'b1;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.restart) |=> (valid_q == '0))
		else $error("restart left moment entries marked valid");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == rmsm_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_item.restart) |=> (count_q >= $past(count_q)))
		else $error("observation count went backwards without restart");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !res_stall))
		else $error("held result overwritten");

endmodule
`default_nettype wire

/* bench/tb_running_mean_second_moment.sv */
// Self-checking testbench of the running mean and second-moment matrix estimator.
`default_nettype none
module tb_running_mean_second_moment;

	localparam int NDIM = 4;
	localparam int N_RANDOM = 340;

	// Directed stimulus row: samples, restart flag and, where obvious, the expected
	// mean of component 0 after absorbing the beat (checked on top of the predictor).
	typedef struct {
		logic signed [15:0] s0, s1, s2, s3;
		bit                 rst;
		bit                 has_mean0;
		logic signed [31:0] mean0;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic obs_valid;
	logic obs_stall;
	rmsm_pkg::obs_t obs;
	logic res_valid;
	logic res_stall;
	rmsm_pkg::res_t res;

	running_mean_second_moment #(.DIM(NDIM)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.obs_valid(obs_valid), .obs_stall(obs_stall), .obs(obs),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	// Predictor state: count, mean vector and second-moment matrix.
	logic [31:0]        n_seen;
	longint             mean_acc [NDIM];
	longint             mom_acc  [NDIM*NDIM];
	rmsm_pkg::res_t     rows_due [$];
	int                 errors;
	int                 rows_checked;
	int                 beats_sent;
	int                 restarts_sent;
	bit                 quiet_rx;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous bound on the length of the whole run.
	initial begin
		#(2 * 1500 * 400 * 3);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint round_div(longint diff, longint unsigned div);
		longint unsigned mag, q;
		mag = diff < 0 ? longint'(-diff) : longint'(diff);
		q = (mag + div / 2) / div;
		return diff < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Absorbs one observation and queues the DIM row results it causes.
	task automatic absorb_observation(input rmsm_pkg::obs_t o);
		longint          x [NDIM];
		longint unsigned div;
		rmsm_pkg::res_t  r;
		if (o.restart) begin
			n_seen = '0;
			foreach (mean_acc[i]) mean_acc[i] = 0;
			foreach (mom_acc[i]) mom_acc[i] = 0;
		end
		x[0] = o.elem_0;
		x[1] = o.elem_1;
		x[2] = o.elem_2;
		x[3] = o.elem_3;
		div = longint'(n_seen) + 1;
		for (int i = 0; i < NDIM; i++) begin
			mean_acc[i] = clamp(mean_acc[i] + round_div(x[i] * 65536 - mean_acc[i], div),
				-64'sd2147483648, 64'sd2147483647);
			for (int j = 0; j < NDIM; j++)
				mom_acc[i*NDIM+j] = clamp(mom_acc[i*NDIM+j]
					+ round_div(x[i] * x[j] * 65536 - mom_acc[i*NDIM+j], div),
					-64'sd140737488355328, 64'sd140737488355327);
		end
		if (n_seen != rmsm_pkg::CNT_MAX)
			n_seen++;
		for (int i = 0; i < NDIM; i++) begin
			r.row_index    = 2'(i);
			r.mean_value   = 32'(mean_acc[i]);
			r.moment_col_0 = 48'(mom_acc[i*NDIM+0]);
			r.moment_col_1 = 48'(mom_acc[i*NDIM+1]);
			r.moment_col_2 = 48'(mom_acc[i*NDIM+2]);
			r.moment_col_3 = 48'(mom_acc[i*NDIM+3]);
			r.obs_count    = n_seen;
			r.last_row     = (i == NDIM - 1);
			rows_due.push_back(r);
		end
	endtask

	// Presents one beat and holds it until accepted; idles at random beforehand.
	task automatic send_observation(input rmsm_pkg::obs_t o, input bit may_idle);
		while (may_idle && $urandom_range(99) < 8) begin
			obs_valid <= 1'b0;
			@(posedge clk);
		end
		obs       <= o;
		obs_valid <= 1'b1;
		absorb_observation(o);
		do @(posedge clk); while (obs_stall);
		beats_sent++;
		if (o.restart)
			restarts_sent++;
	endtask

	// Result side: random stall, compared field by field with the oldest expectation.
	always @(posedge clk) begin
		rmsm_pkg::res_t e;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 8);
			if (res_valid && !res_stall) begin
				rows_checked++;
				if (rows_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected row result %p", $time, res);
				end else begin
					e = rows_due.pop_front();
					if (res.row_index !== e.row_index) begin
						errors++;
						$display("%0t: row_index exp %0d got %0d", $time,
							e.row_index, res.row_index);
					end
					if (res.mean_value !== e.mean_value) begin
						errors++;
						$display("%0t: mean_value row %0d exp %0d got %0d", $time,
							e.row_index, e.mean_value, res.mean_value);
					end
					if (res.moment_col_0 !== e.moment_col_0) begin
						errors++;
						$display("%0t: moment_col_0 row %0d exp %0d got %0d", $time,
							e.row_index, e.moment_col_0, res.moment_col_0);
					end
					if (res.moment_col_1 !== e.moment_col_1) begin
						errors++;
						$display("%0t: moment_col_1 row %0d exp %0d got %0d", $time,
							e.row_index, e.moment_col_1, res.moment_col_1);
					end
					if (res.moment_col_2 !== e.moment_col_2) begin
						errors++;
						$display("%0t: moment_col_2 row %0d exp %0d got %0d", $time,
							e.row_index, e.moment_col_2, res.moment_col_2);
					end
					if (res.moment_col_3 !== e.moment_col_3) begin
						errors++;
						$display("%0t: moment_col_3 row %0d exp %0d got %0d", $time,
							e.row_index, e.moment_col_3, res.moment_col_3);
					end
					if (res.obs_count !== e.obs_count) begin
						errors++;
						$display("%0t: obs_count exp %0d got %0d", $time,
							e.obs_count, res.obs_count);
					end
					if (res.last_row !== e.last_row) begin
						errors++;
						$display("%0t: last_row exp %0b got %0b", $time,
							e.last_row, res.last_row);
					end
				end
			end
		end
	end

	// Checks the hand-written mean of component 0 against the predictor's queued row for the beat.
	task automatic check_directed_mean(input stim_row_t row);
		rmsm_pkg::res_t e;
		e = rows_due[rows_due.size() - NDIM];
		if (row.has_mean0 && e.mean_value !== row.mean0) begin
			errors++;
			$display("%0t: directed mean exp %0d got %0d", $time, row.mean0, e.mean_value);
		end
	endtask

	initial begin
		stim_row_t      table_rows [$];
		stim_row_t      sr;
		rmsm_pkg::obs_t o;

		arst_n = 1'b0;
		obs_valid = 1'b0;
		obs = '0;
		quiet_rx = 1'b0;
		errors = 0;
		rows_checked = 0;
		beats_sent = 0;
		restarts_sent = 0;
		n_seen = '0;
		foreach (mean_acc[i]) mean_acc[i] = 0;
		foreach (mom_acc[i]) mom_acc[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First beat after reset: the mean equals the sample itself.
		table_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'sd0});
		table_rows.push_back('{16'sd2, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 32'sd65536});
		// Restart then full-scale extremes, positive and negative.
		table_rows.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1,
			1'b1, 32'sd2147418112});
		table_rows.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0,
			1'b1, -32'sd32768});
		table_rows.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
			1'b1, -32'sd2147483648});
		table_rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0,
			1'b0, 32'sd0});
		// Rounding: small samples of 0 and +-1 over growing divisors.
		table_rows.push_back('{16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b1, 1'b1, 32'sd65536});
		table_rows.push_back('{16'sd0, 16'sd0, 16'sd1, -16'sd1, 1'b0, 1'b1, 32'sd32768});
		table_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 32'sd0});
		table_rows.push_back('{-16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b0, 1'b0, 32'sd0});
		table_rows.push_back('{16'sh5555, -16'sh5556, 16'sh2AAA, 16'sh7FFE, 1'b0, 1'b0, 32'sd0});
		table_rows.push_back('{-16'sh2AAB, 16'sh0001, -16'sh7FFF, 16'sh0100, 1'b1, 1'b0, 32'sd0});

		foreach (table_rows[k]) begin
			sr = table_rows[k];
			o = '{elem_0: sr.s0, elem_1: sr.s1, elem_2: sr.s2, elem_3: sr.s3, restart: sr.rst};
			send_observation(o, 1'b1);
			check_directed_mean(sr);
		end

		// Random part: mostly runs of growing count, sometimes restarted; a quiet stretch
		// with no idling on either side sits in the middle.
		for (int k = 0; k < N_RANDOM; k++) begin
			quiet_rx = (k >= 120 && k < 170);
			o.elem_0  = 16'($urandom);
			o.elem_1  = 16'($urandom);
			o.elem_2  = 16'($urandom);
			o.elem_3  = 16'($urandom);
			if ($urandom_range(9) == 0)
				o.elem_0 = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			o.restart = ($urandom_range(29) == 0);
			send_observation(o, !quiet_rx);
		end
		obs_valid <= 1'b0;
		quiet_rx = 1'b0;

		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);

		$display("Absorbed %0d observations (%0d with restart) and checked %0d row results.",
			beats_sent, restarts_sent, rows_checked);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

/* running_mean_second_moment.f */
rtl/rmsm_pkg.sv
rtl/rmsm_queue.sv
rtl/rmsm_div.sv
rtl/rmsm_back.sv
rtl/running_mean_second_moment.sv
bench/tb_running_mean_second_moment.sv
